@@ sv/bbd_pkg.sv @@
// Package: request codes, state codes and bus widths for the actor-movie distance engine.
package bbd_pkg;
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam int   FIELD_W   = 11;
    localparam int   IN_DATA_W = 48;
    localparam int   OUT_DATA_W = 16;
    localparam int   ST_W      = 4;
    localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [ST_W-1:0] ST_LINK2  = 4'd1;
    localparam logic [ST_W-1:0] ST_CLEAR  = 4'd2;
    localparam logic [ST_W-1:0] ST_POP    = 4'd3;
    localparam logic [ST_W-1:0] ST_HEAD   = 4'd4;
    localparam logic [ST_W-1:0] ST_SLOT   = 4'd5;
    localparam logic [ST_W-1:0] ST_VIS    = 4'd6;
    localparam logic [ST_W-1:0] ST_DONE   = 4'd7;
    localparam logic [ST_W-1:0] ST_RESULT = 4'd8;
    localparam logic [ST_W-1:0] ST_INIT   = 4'd9;
    localparam logic [ST_W-1:0] ST_DIST   = 4'd10;
    localparam logic [ST_W-1:0] ST_LINK1  = 4'd11;
    localparam logic [ST_W-1:0] ST_LOAD   = 4'd12;
    localparam logic [ST_W-1:0] ST_VREAD  = 4'd13;
endpackage

@@ sv/bipartite_bfs_distance.sv @@
// Top level: bipartite graph store with breadth-first actor distance search.
// Add-edge beat: accept, then nbr, next and head writes per adjacency link, no result.
// Query beat: accept, visited-map clear over all nodes, then POP, HEAD, LOAD per node
//   popped plus SLOT, VREAD, VIS per slot walked, DONE and DIST to fetch the distance;
//   result held until taken. Equal/out-of-range actors skip search. One item at a time.
// Reset: synchronous; a pass over all nodes empties all list heads before the first
//   beat is accepted; slot count and dropped flag return to zero.
module bipartite_bfs_distance #(
    parameter int ACTOR_COUNT = 2048,
    parameter int MOVIE_COUNT = 2048,
    parameter int EDGE_COUNT  = 16384
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: actor_id[10:0], movie_id[21:11], source_actor[32:22], target_actor[43:33]
    input  logic [bbd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: reachable[0], hops[11:1], edges_dropped[12]
    output logic [bbd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    localparam int NODE_TOTAL = ACTOR_COUNT + MOVIE_COUNT;
    localparam int SLOT_TOTAL = 2 * EDGE_COUNT;
    localparam int NW  = $clog2(NODE_TOTAL);
    localparam int SW  = $clog2(SLOT_TOTAL);
    localparam int LW  = $clog2(SLOT_TOTAL + 1);
    localparam int QW  = $clog2(NODE_TOTAL + 1);
    localparam int DW  = NW + 1;
    localparam int FW  = bbd_pkg::FIELD_W;
    localparam logic [FW-1:0] HOPS_MAX = {FW{1'b1}};

    // memories
    logic [LW-1:0] m_head [NODE_TOTAL];
    logic [NW-1:0] m_nbr  [SLOT_TOTAL];
    logic [LW-1:0] m_next [SLOT_TOTAL];
    logic          m_vis  [NODE_TOTAL];
    logic [DW-1:0] m_dist [NODE_TOTAL];
    logic [NW-1:0] m_q    [NODE_TOTAL];

    logic [bbd_pkg::ST_W-1:0] r_st, n_st;
    logic [NW-1:0] r_idx;
    logic [LW-1:0] r_used;
    logic          r_full;
    logic [NW-1:0] r_a, r_m, r_src, r_dst, r_u;
    logic [LW-1:0] r_link;
    logic [QW-1:0] r_rd, r_wr;
    logic [DW-1:0] r_du;
    logic          r_found;
    logic          r_reach;
    logic [FW-1:0] r_hops;

    // registered read data
    logic [LW-1:0] r_head_q;
    logic [NW-1:0] r_nbr_q;
    logic [LW-1:0] r_next_q;
    logic          r_vis_q;
    logic [DW-1:0] r_dist_q;
    logic [NW-1:0] r_q_q;

    logic [FW-1:0] w_act, w_mov, w_s, w_t;
    assign w_act = s_axis_tdata[FW-1:0];
    assign w_mov = s_axis_tdata[2*FW-1:FW];
    assign w_s   = s_axis_tdata[3*FW-1:2*FW];
    assign w_t   = s_axis_tdata[4*FW-1:3*FW];

    assign s_axis_tready = (r_st == bbd_pkg::ST_IDLE);
    assign m_axis_tvalid = (r_st == bbd_pkg::ST_RESULT);
    assign m_axis_tdata  = {{(bbd_pkg::OUT_DATA_W-FW-2){1'b0}}, r_full, r_hops, r_reach};

    logic w_acc;
    assign w_acc = s_axis_tvalid && s_axis_tready;

    // read ports, one address per memory per cycle
    logic [NW-1:0] w_head_ra, w_vis_ra, w_dist_ra;
    logic [SW-1:0] w_slot_ra;
    always_comb begin
        w_head_ra = r_u;
        w_vis_ra  = r_nbr_q;
        w_dist_ra = (r_st == bbd_pkg::ST_DONE) ? r_dst : r_u;
        w_slot_ra = SW'(r_link - LW'(1));
        if (r_st == bbd_pkg::ST_IDLE) begin
            w_head_ra = NW'(w_act);
        end else if (r_st == bbd_pkg::ST_LINK1) begin
            w_head_ra = NW'(ACTOR_COUNT + int'(r_m));
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_q <= m_head[w_head_ra];
        r_nbr_q  <= m_nbr[w_slot_ra];
        r_next_q <= m_next[w_slot_ra];
        r_vis_q  <= m_vis[w_vis_ra];
        r_dist_q <= m_dist[w_dist_ra];
        r_q_q    <= m_q[r_rd[NW-1:0]];
    end

    // control sequencer
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            bbd_pkg::ST_INIT:   if (int'(r_idx) == NODE_TOTAL - 1) n_st = bbd_pkg::ST_IDLE;
            bbd_pkg::ST_IDLE: begin
                if (w_acc) begin
                    if (s_axis_tuser == bbd_pkg::REQ_ADD) begin
                        if (int'(w_act) < ACTOR_COUNT && int'(w_mov) < MOVIE_COUNT &&
                            (SLOT_TOTAL - int'(r_used)) >= 2)
                            n_st = bbd_pkg::ST_LINK1;
                    end else if (w_s == w_t) begin
                        n_st = bbd_pkg::ST_RESULT;
                    end else if (int'(w_s) < ACTOR_COUNT && int'(w_t) < ACTOR_COUNT) begin
                        n_st = bbd_pkg::ST_CLEAR;
                    end else begin
                        n_st = bbd_pkg::ST_RESULT;
                    end
                end
            end
            bbd_pkg::ST_LINK1:  n_st = bbd_pkg::ST_LINK2;
            bbd_pkg::ST_LINK2:  n_st = bbd_pkg::ST_IDLE;
            bbd_pkg::ST_CLEAR:  if (int'(r_idx) == NODE_TOTAL - 1) n_st = bbd_pkg::ST_POP;
            bbd_pkg::ST_POP:    n_st = (r_found || r_rd == r_wr) ? bbd_pkg::ST_DONE
                                                                  : bbd_pkg::ST_HEAD;
            bbd_pkg::ST_HEAD:   n_st = bbd_pkg::ST_LOAD;
            bbd_pkg::ST_LOAD:   n_st = bbd_pkg::ST_SLOT;
            bbd_pkg::ST_SLOT:   n_st = (r_link == '0 || r_found) ? bbd_pkg::ST_POP
                                                                   : bbd_pkg::ST_VREAD;
            bbd_pkg::ST_VREAD:  n_st = bbd_pkg::ST_VIS;
            bbd_pkg::ST_VIS:    n_st = bbd_pkg::ST_SLOT;
            bbd_pkg::ST_DONE:   n_st = bbd_pkg::ST_DIST;
            bbd_pkg::ST_DIST:   n_st = bbd_pkg::ST_RESULT;
            bbd_pkg::ST_RESULT: if (m_axis_tready) n_st = bbd_pkg::ST_IDLE;
            default:            n_st = bbd_pkg::ST_INIT;
        endcase
    end

    // memory writes
    always_ff @(posedge i_clk) begin
        if (r_st == bbd_pkg::ST_INIT) m_head[r_idx] <= '0;
        // link actor to movie, old actor head read during accept
        if (r_st == bbd_pkg::ST_LINK1) begin
            m_nbr[r_used[SW-1:0]]  <= NW'(ACTOR_COUNT + int'(r_m));
            m_next[r_used[SW-1:0]] <= r_head_q;
            m_head[r_a]            <= r_used + LW'(1);
        end
        // link movie to actor, old movie head read during the first link
        if (r_st == bbd_pkg::ST_LINK2) begin
            m_nbr[r_used[SW-1:0]]  <= r_a;
            m_next[r_used[SW-1:0]] <= r_head_q;
            m_head[NW'(ACTOR_COUNT + int'(r_m))] <= r_used + LW'(1);
        end
        if (r_st == bbd_pkg::ST_CLEAR) m_vis[r_idx] <= (r_idx == r_src);
        if (r_st == bbd_pkg::ST_IDLE && n_st == bbd_pkg::ST_CLEAR) begin
            m_dist[NW'(w_s)] <= '0;
            m_q[0]           <= NW'(w_s);
        end
        if (r_st == bbd_pkg::ST_VIS && !r_vis_q && int'(r_wr) < NODE_TOTAL) begin
            m_vis[r_nbr_q]          <= 1'b1;
            m_dist[r_nbr_q]         <= r_du + DW'(1);
            m_q[r_wr[NW-1:0]]       <= r_nbr_q;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= bbd_pkg::ST_INIT;
            r_idx  <= '0;
            r_used <= '0;
            r_full <= 1'b0;
        end else begin
            r_st <= n_st;
            if (r_st == bbd_pkg::ST_INIT || r_st == bbd_pkg::ST_CLEAR)
                r_idx <= (int'(r_idx) == NODE_TOTAL - 1) ? '0 : r_idx + NW'(1);
            if (r_st == bbd_pkg::ST_IDLE && w_acc && s_axis_tuser == bbd_pkg::REQ_ADD &&
                int'(w_act) < ACTOR_COUNT && int'(w_mov) < MOVIE_COUNT &&
                (SLOT_TOTAL - int'(r_used)) < 2)
                r_full <= 1'b1;
            if (r_st == bbd_pkg::ST_LINK1 || r_st == bbd_pkg::ST_LINK2)
                r_used <= r_used + LW'(1);
        end
        // capture item
        if (r_st == bbd_pkg::ST_IDLE && w_acc) begin
            r_a     <= NW'(w_act);
            r_m     <= NW'(w_mov);
            r_src   <= NW'(w_s);
            r_dst   <= NW'(w_t);
            r_rd    <= '0;
            r_wr    <= QW'(1);
            r_found <= 1'b0;
            r_reach <= (w_s == w_t);
            r_hops  <= '0;
        end
        // pop: queue word read last cycle at r_rd
        if (r_st == bbd_pkg::ST_POP && !(r_found || r_rd == r_wr)) begin
            r_rd <= r_rd + QW'(1);
            r_u  <= r_q_q;
        end
        // take list head and distance of the popped node
        if (r_st == bbd_pkg::ST_LOAD) begin
            r_link <= r_head_q;
            r_du   <= r_dist_q;
        end
        if (r_st == bbd_pkg::ST_VIS) begin
            r_link <= r_next_q;
            if (!r_vis_q && int'(r_wr) < NODE_TOTAL) begin
                r_wr <= r_wr + QW'(1);
                if (r_nbr_q == r_dst) r_found <= 1'b1;
            end
        end
        if (r_st == bbd_pkg::ST_DIST) begin
            r_reach <= r_found;
            r_hops  <= r_found ? ((int'(r_dist_q >> 1) > int'(HOPS_MAX)) ? HOPS_MAX
                                  : FW'(r_dist_q >> 1)) : '0;
        end
    end
endmodule

@@ bench/tb_bipartite_bfs_distance.sv @@
// Testbench for the actor-movie distance engine: random and directed edge/query beats.
`timescale 1ns / 1ps

module tb_bipartite_bfs_distance;
    localparam int ACTORS   = 2048;
    localparam int MOVIES   = 2048;
    localparam int EDGES    = 16384;
    localparam int NODES    = ACTORS + MOVIES;
    localparam int SLOTS    = 2 * EDGES;
    localparam int WD_LIMIT = 2000000;

    typedef struct packed {
        logic        req;
        logic [10:0] actor;
        logic [10:0] movie;
        logic [10:0] src;
        logic [10:0] dst;
    } t_req;

    typedef struct packed {
        logic        reachable;
        logic [10:0] hops;
        logic        dropped;
    } t_answer;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [bbd_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [bbd_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    bipartite_bfs_distance u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Graph mirror
    int      head_of[NODES];
    int      nbr_of[SLOTS];
    int      next_of[SLOTS];
    int      used_slots = 0;
    bit      full_flag = 1'b0;
    bit      seen[NODES];
    int      dist_of[NODES];
    int      bfs_fifo[NODES];

    t_req    pending_beats[$];
    t_answer expected_answers[$];
    int      errors = 0;
    bit      hold_send = 1'b0;
    int      idle_cycles = 0;
    int      send_gap = 0;

    function automatic void add_link(int from, int to);
        nbr_of[used_slots]  = to;
        next_of[used_slots] = head_of[from];
        head_of[from] = used_slots + 1;
        used_slots++;
    endfunction

    function automatic int bfs_distance(int src, int dst);
        int rd, wr, u, lnk, v;
        rd = 0;
        wr = 0;
        foreach (seen[i]) seen[i] = 0;
        seen[src] = 1;
        dist_of[src] = 0;
        bfs_fifo[wr++] = src;
        while (rd < wr && !seen[dst]) begin
            u = bfs_fifo[rd++];
            lnk = head_of[u];
            while (lnk != 0 && !seen[dst]) begin
                v = nbr_of[lnk-1];
                if (!seen[v] && wr < NODES) begin
                    seen[v] = 1;
                    dist_of[v] = dist_of[u] + 1;
                    bfs_fifo[wr++] = v;
                end
                lnk = next_of[lnk-1];
            end
        end
        return seen[dst] ? dist_of[dst] : -1;
    endfunction

    // Advance the mirror by one accepted beat and queue any answer
    function automatic void predict_beat(t_req r);
        t_answer a;
        int d;
        if (r.req == bbd_pkg::REQ_ADD) begin
            if (r.actor < ACTORS && r.movie < MOVIES) begin
                if (SLOTS - used_slots < 2) full_flag = 1;
                else begin
                    add_link(int'(r.actor), ACTORS + int'(r.movie));
                    add_link(ACTORS + int'(r.movie), int'(r.actor));
                end
            end
            return;
        end
        a = '0;
        if (r.src == r.dst) a.reachable = 1'b1;
        else if (r.src < ACTORS && r.dst < ACTORS) begin
            d = bfs_distance(int'(r.src), int'(r.dst));
            if (d >= 0) begin
                a.reachable = 1'b1;
                a.hops = (d / 2 > 2047) ? 11'd2047 : 11'(d / 2);
            end
        end
        a.dropped = full_flag;
        expected_answers.insert(expected_answers.size(), a);
    endfunction

    function automatic void queue_beat(t_req r);
        pending_beats.insert(pending_beats.size(), r);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_req mk(logic t, int a, int m, int s, int d);
        t_req r;
        r.req = t; r.actor = 11'(a); r.movie = 11'(m); r.src = 11'(s); r.dst = 11'(d);
        return r;
    endfunction

    // Driver: present queued beats with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_beat(pending_beats.pop_front());
                send_gap <= gap_len();
                s_axis_tvalid <= 1'b0;
            end else if (!s_axis_tvalid) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                else if (!hold_send && pending_beats.size() > 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_beats[0].req;
                    s_axis_tdata  <= {4'b0, pending_beats[0].dst, pending_beats[0].src,
                                      pending_beats[0].movie, pending_beats[0].actor};
                end
            end
        end
    end

    // Monitor: random backpressure and field checks
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = t_answer'({m_axis_tdata[0], m_axis_tdata[11:1], m_axis_tdata[12]});
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected result beat", int'(m_axis_tdata), 0);
                end else begin
                    want = expected_answers.pop_front();
                    if (got.reachable != want.reachable)
                        report_mismatch("reachable", got.reachable, want.reachable);
                    if (got.hops != want.hops) report_mismatch("hops", got.hops, want.hops);
                    if (got.dropped != want.dropped)
                        report_mismatch("edges_dropped", got.dropped, want.dropped);
                end
            end
            m_axis_tready <= (gap_len() == 0);
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("bipartite_bfs_distance regression: fail");
            $finish;
        end
    end

    // Stimulus: small actor/movie pools make paths likely
    initial begin
        int n, pool, k;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, equal actors, no path, chain, duplicates
        queue_beat(mk(bbd_pkg::REQ_QUERY, 0, 0, 5, 5));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 0, 0, 2047, 2047));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 0, 0, 0, 2047));
        queue_beat(mk(bbd_pkg::REQ_ADD, 0, 0, 0, 0));
        queue_beat(mk(bbd_pkg::REQ_ADD, 2047, 0, 0, 0));
        queue_beat(mk(bbd_pkg::REQ_ADD, 2047, 2047, 2047, 2047));
        queue_beat(mk(bbd_pkg::REQ_ADD, 1, 2047, 0, 0));
        queue_beat(mk(bbd_pkg::REQ_ADD, 1, 2047, 0, 0));
        queue_beat(mk(bbd_pkg::REQ_ADD, 1364, 682, 1365, 682));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 2047, 2047, 0, 2047));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 0, 0, 0, 1));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 0, 0, 1, 2047));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 0, 0, 0, 3));
        queue_beat(mk(bbd_pkg::REQ_QUERY, 2047, 2047, 1365, 682));

        wait (pending_beats.size() == 0);
        hold_send = 1;
        wait (expected_answers.size() == 0);
        hold_send = 0;

        // Random: edges and queries in a pool, small for 50 beats, then all actors
        n = 0;
        pool = 12;
        while (n < 100) begin
            k = $urandom_range(0, 99);
            if (k < 55)
                queue_beat(mk(bbd_pkg::REQ_ADD, $urandom_range(0, pool),
                    $urandom_range(0, pool), $urandom, $urandom));
            else if (k < 90)
                queue_beat(mk(bbd_pkg::REQ_QUERY, $urandom, $urandom,
                    $urandom_range(0, pool), $urandom_range(0, pool)));
            else
                queue_beat(mk(1'($urandom_range(0, 1)), $urandom, $urandom,
                    $urandom, $urandom));
            n++;
            if (n == 50) pool = 2047;
        end

        wait (pending_beats.size() == 0);
        wait (expected_answers.size() == 0);
        repeat (NODES * 4) @(posedge i_clk);
        if (errors == 0 && expected_answers.size() == 0)
            $display("bipartite_bfs_distance regression: pass");
        else
            $display("bipartite_bfs_distance regression: fail");
        $finish;
    end
endmodule

@@ bipartite_bfs_distance.f @@
sv/bbd_pkg.sv
sv/bipartite_bfs_distance.sv
bench/tb_bipartite_bfs_distance.sv
